[design/assert_macros.svh]
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, switched off while reset is held
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property that also holds through reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/arp_rsp_pkg.sv]
`default_nettype none
package arp_rsp_pkg;

    // frame byte counter
    localparam int CNT_W = 11;
    localparam logic [CNT_W-1:0] COUNT_SAT = 11'd2047;
    localparam logic [CNT_W-1:0] MAX_FRAME = 11'd1514;
    localparam logic [CNT_W-1:0] MIN_FRAME = 11'd42;

    // reply sequencer index
    typedef logic [5:0] t_rep_idx;
    localparam t_rep_idx REPLY_LAST = 6'd41;

    // register reset values
    localparam logic [47:0] LOCAL_MAC_RST = 48'h0200_0000_0002;
    localparam logic [31:0] LOCAL_IP_RST  = 32'h0A00_0002;

    // register decode on paddr[3]
    localparam logic REG_LOCAL_MAC = 1'b0;
    localparam logic REG_LOCAL_IP  = 1'b1;

    // arp opcode bytes: high byte, then request / reply low bytes
    localparam logic [7:0] OPER_HI      = 8'h00;
    localparam logic [7:0] OPER_REQUEST = 8'h01;
    localparam logic [7:0] OPER_REPLY   = 8'h02;

    typedef enum logic [1:0] {
        ST_REPLY       = 2'd0,
        ST_MALFORMED   = 2'd1,
        ST_NOT_REQUEST = 2'd2,
        ST_NOT_FOR_US  = 2'd3
    } t_status;

    // frame parser to transmit side
    typedef struct packed {
        logic        start;
        logic        stat_load;
        t_status     status;
        logic [47:0] peer_mac;
        logic [31:0] peer_ip;
    } t_tx_req;

    // transmit side to frame parser
    typedef struct packed {
        logic busy;
        logic can_take;
    } t_tx_sts;

    // ethertype plus fixed arp header, frame bytes 12 to 19
    function automatic logic [7:0] hdr_byte(input logic [2:0] i);
        logic [7:0] b;
        case (i)
            3'd0: b = 8'h08;
            3'd1: b = 8'h06;
            3'd2: b = 8'h00;
            3'd3: b = 8'h01;
            3'd4: b = 8'h08;
            3'd5: b = 8'h00;
            3'd6: b = 8'h06;
            3'd7: b = 8'h04;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] i);
        logic [7:0] b;
        case (i)
            3'd0: b = mac[47:40];
            3'd1: b = mac[39:32];
            3'd2: b = mac[31:24];
            3'd3: b = mac[23:16];
            3'd4: b = mac[15:8];
            3'd5: b = mac[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] i);
        logic [7:0] b;
        case (i)
            2'd0: b = ip[31:24];
            2'd1: b = ip[23:16];
            2'd2: b = ip[15:8];
            2'd3: b = ip[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // byte k of the 42-byte reply frame
    function automatic logic [7:0] reply_byte(
        input t_rep_idx    k,
        input logic [47:0] peer_mac,
        input logic [31:0] peer_ip,
        input logic [47:0] own_mac,
        input logic [31:0] own_ip
    );
        logic [7:0] b;
        if (k < 6'd6) begin
            b = mac_byte(peer_mac, k[2:0]);
        end else if (k < 6'd12) begin
            b = mac_byte(own_mac, 3'(k - 6'd6));
        end else if (k < 6'd20) begin
            b = hdr_byte(3'(k - 6'd12));
        end else if (k == 6'd20) begin
            b = OPER_HI;
        end else if (k == 6'd21) begin
            b = OPER_REPLY;
        end else if (k < 6'd28) begin
            b = mac_byte(own_mac, 3'(k - 6'd22));
        end else if (k < 6'd32) begin
            b = ip_byte(own_ip, 2'(k - 6'd28));
        end else if (k < 6'd38) begin
            b = mac_byte(peer_mac, 3'(k - 6'd32));
        end else begin
            b = ip_byte(peer_ip, 2'(k - 6'd38));
        end
        return b;
    endfunction

endpackage
`default_nettype wire

[design/arp_rsp_rx_if.sv]
`default_nettype none
// receive byte channel
interface arp_rsp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       rx_last;

    modport source (output valid, output rx_byte, output rx_last, input ready);
    modport sink   (input valid, input rx_byte, input rx_last, output ready);
endinterface
`default_nettype wire

[design/arp_rsp_tx_if.sv]
`default_nettype none
// reply / status channel
interface arp_rsp_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       has_data;
    logic       tx_last;
    logic [1:0] status;

    modport source (output valid, output tx_byte, output has_data, output tx_last,
                    output status, input ready);
    modport sink   (input valid, input tx_byte, input has_data, input tx_last,
                    input status, output ready);
endinterface
`default_nettype wire

[design/arp_rsp_tx.sv]
`default_nettype none
`include "assert_macros.svh"
module arp_rsp_tx (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  arp_rsp_pkg::t_tx_req i_req,
    input  logic [47:0]          i_local_mac,
    input  logic [31:0]          i_local_ip,
    output arp_rsp_pkg::t_tx_sts o_sts,
    arp_rsp_tx_if.source         o_tx
);
    import arp_rsp_pkg::*;

    logic        r_active, n_active;
    t_rep_idx    r_idx, n_idx;
    logic        r_out_valid, n_out_valid;
    logic [47:0] r_peer_mac;
    logic [31:0] r_peer_ip;
    logic [7:0]  r_tx_byte;
    logic        r_has_data;
    logic        r_tx_last;
    t_status     r_status;

    logic w_free;
    logic w_load_reply;
    logic w_load_stat;

    // output register can take a new transaction
    assign w_free       = !r_out_valid || o_tx.ready;
    assign w_load_reply = r_active && w_free;
    assign w_load_stat  = i_req.stat_load;

    // sequencer and output valid next state
    always_comb begin
        n_active    = r_active;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (w_load_reply) begin
            n_out_valid = 1'b1;
            if (r_idx == REPLY_LAST) begin
                n_active = 1'b0;
                n_idx    = '0;
            end else begin
                n_idx = r_idx + 6'd1;
            end
        end else if (w_load_stat) begin
            n_out_valid = 1'b1;
        end else if (w_free) begin
            n_out_valid = 1'b0;
        end
        if (i_req.start) begin
            n_active = 1'b1;
            n_idx    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_load_reply) begin
            r_tx_byte  <= reply_byte(r_idx, r_peer_mac, r_peer_ip, i_local_mac, i_local_ip);
            r_has_data <= 1'b1;
            r_tx_last  <= (r_idx == REPLY_LAST);
            r_status   <= ST_REPLY;
        end else if (w_load_stat) begin
            r_tx_byte  <= 8'h00;
            r_has_data <= 1'b0;
            r_tx_last  <= 1'b1;
            r_status   <= i_req.status;
        end
        if (i_req.start) begin
            r_peer_mac <= i_req.peer_mac;
            r_peer_ip  <= i_req.peer_ip;
        end
    end

    assign o_tx.valid    = r_out_valid;
    assign o_tx.tx_byte  = r_tx_byte;
    assign o_tx.has_data = r_has_data;
    assign o_tx.tx_last  = r_tx_last;
    assign o_tx.status   = r_status;

    assign o_sts.busy     = r_active;
    assign o_sts.can_take = !r_active && w_free;

    // checks
    `ASSERT_CHK(a_start_idle, i_clk, i_rst_n, i_req.start |-> !r_active && !i_req.stat_load, "reply started while busy")
    `ASSERT_CHK(a_stat_free, i_clk, i_rst_n, i_req.stat_load |-> w_free && !r_active, "status result would overwrite")
    `ASSERT_CHK(a_idx_range, i_clk, i_rst_n, r_active |-> r_idx <= REPLY_LAST, "reply index past end")
    `ASSERT_CHK(a_last_ends, i_clk, i_rst_n, (w_load_reply && r_idx == REPLY_LAST) |=> !r_active && r_tx_last, "reply did not end")
    `ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !r_active && !r_out_valid, "not idle after reset")

endmodule
`default_nettype wire

[design/arp_request_responder.sv]
`default_nettype none
// ARP request responder
// i_rx carries a received Ethernet frame one byte per transaction, starting
// at the destination MAC, with rx_last on the final byte. o_tx carries the
// results: for a valid ARP request for local_ip, 42 reply bytes (has_data 1,
// status 0, tx_last on the 42nd); otherwise one status-only transaction with
// tx_last set and status 1 malformed/not ARP, 2 not a request, 3 not for us.
// Non-final bytes give no result and are taken every cycle.
// A status result is valid the cycle after its final byte is taken; a reply
// first starts the sequencer, then loads one byte per cycle while o_tx.ready.
// Throughput: one received byte per cycle while ready is high. The next frame
// streams in while a reply is sent; its final byte is held off (ready low) until
// the 42-byte reply sequencer is idle and the output register is free.
// A stalled receiver holds the output register and the reply sequencer.
// Reset (synchronous, active low) clears the frame state, drops any pending
// result and returns local_mac / local_ip to their defaults.
// Registers over APB: local_mac at 0x0, local_ip at 0x8, 64-bit data.
module arp_request_responder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    arp_rsp_rx_if.sink  i_rx,
    arp_rsp_tx_if.source o_tx,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import arp_rsp_pkg::*;

    logic [47:0]      r_local_mac;
    logic [31:0]      r_local_ip;
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic             r_header_bad, n_header_bad;
    logic             r_opcode_bad, n_opcode_bad;
    logic             r_target_bad, n_target_bad;
    logic [47:0]      r_sender_mac, n_sender_mac;
    logic [31:0]      r_sender_ip, n_sender_ip;

    logic             w_acc;
    logic             w_wr;
    logic [7:0]       w_b;
    logic [CNT_W-1:0] w_pos;
    logic [CNT_W-1:0] w_len;
    logic             w_tip_miss;
    t_status          w_status;
    t_tx_req          w_req;
    t_tx_sts          w_sts;

    // configuration port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_mac <= LOCAL_MAC_RST;
            r_local_ip  <= LOCAL_IP_RST;
        end else if (w_wr) begin
            if (paddr[3] == REG_LOCAL_MAC) begin
                r_local_mac <= pwdata[47:0];
            end else begin
                r_local_ip <= pwdata[31:0];
            end
        end
    end

    always_comb begin
        if (paddr[3] == REG_LOCAL_IP) begin
            prdata = {32'h0, r_local_ip};
        end else begin
            prdata = {16'h0, r_local_mac};
        end
    end

    // receive handshake: a final byte waits for the transmit side
    assign i_rx.ready = !i_rx.rx_last || w_sts.can_take;
    assign w_acc      = i_rx.valid && i_rx.ready;
    assign w_b        = i_rx.rx_byte;
    assign w_pos      = r_byte_count;

    // frame length including this byte, saturating
    assign w_len = (r_byte_count == COUNT_SAT) ? COUNT_SAT : r_byte_count + 11'd1;

    // target ip byte differs from local_ip
    assign w_tip_miss = (w_pos >= 11'd38) && (w_pos < 11'd42) &&
                        (w_b != ip_byte(r_local_ip, 2'(w_pos - 11'd38)));

    // verdict for the frame ending at this byte
    always_comb begin
        if (w_len < MIN_FRAME || w_len > MAX_FRAME || r_header_bad) begin
            w_status = ST_MALFORMED;
        end else if (r_opcode_bad) begin
            w_status = ST_NOT_REQUEST;
        end else if (r_target_bad || w_tip_miss) begin
            w_status = ST_NOT_FOR_US;
        end else begin
            w_status = ST_REPLY;
        end
    end

    // per-byte header checks and capture
    always_comb begin
        n_byte_count = r_byte_count;
        n_header_bad = r_header_bad;
        n_opcode_bad = r_opcode_bad;
        n_target_bad = r_target_bad;
        n_sender_mac = r_sender_mac;
        n_sender_ip  = r_sender_ip;
        if (w_acc) begin
            if (w_pos >= 11'd12 && w_pos < 11'd20) begin
                if (w_b != hdr_byte(3'(w_pos - 11'd12))) n_header_bad = 1'b1;
            end else if (w_pos == 11'd20) begin
                if (w_b != OPER_HI) n_opcode_bad = 1'b1;
            end else if (w_pos == 11'd21) begin
                if (w_b != OPER_REQUEST) n_opcode_bad = 1'b1;
            end else if (w_pos >= 11'd22 && w_pos < 11'd28) begin
                n_sender_mac = {r_sender_mac[39:0], w_b};
            end else if (w_pos >= 11'd28 && w_pos < 11'd32) begin
                n_sender_ip = {r_sender_ip[23:0], w_b};
            end else if (w_pos >= 11'd38 && w_pos < 11'd42) begin
                if (w_tip_miss) n_target_bad = 1'b1;
            end
            n_byte_count = w_len;
            if (i_rx.rx_last) begin
                n_byte_count = '0;
                n_header_bad = 1'b0;
                n_opcode_bad = 1'b0;
                n_target_bad = 1'b0;
                n_sender_mac = '0;
                n_sender_ip  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_header_bad <= 1'b0;
            r_opcode_bad <= 1'b0;
            r_target_bad <= 1'b0;
            r_sender_mac <= '0;
            r_sender_ip  <= '0;
        end else begin
            r_byte_count <= n_byte_count;
            r_header_bad <= n_header_bad;
            r_opcode_bad <= n_opcode_bad;
            r_target_bad <= n_target_bad;
            r_sender_mac <= n_sender_mac;
            r_sender_ip  <= n_sender_ip;
        end
    end

    // request to the transmit side
    always_comb begin
        w_req.start     = w_acc && i_rx.rx_last && (w_status == ST_REPLY);
        w_req.stat_load = w_acc && i_rx.rx_last && (w_status != ST_REPLY);
        w_req.status    = w_status;
        w_req.peer_mac  = r_sender_mac;
        w_req.peer_ip   = r_sender_ip;
    end

    arp_rsp_tx u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_local_mac (r_local_mac),
        .i_local_ip  (r_local_ip),
        .o_sts       (w_sts),
        .o_tx        (o_tx)
    );

    // checks
    `ASSERT_CHK(a_last_clears, i_clk, i_rst_n, (w_acc && i_rx.rx_last) |=> r_byte_count == '0 && !r_header_bad, "frame state not cleared")
    `ASSERT_CHK(a_last_blocked, i_clk, i_rst_n, (i_rx.valid && i_rx.rx_last && w_sts.busy) |-> !i_rx.ready, "final byte taken during reply")
    `ASSERT_CHK(a_count_moves, i_clk, i_rst_n, (w_acc && !i_rx.rx_last && r_byte_count != COUNT_SAT) |=> r_byte_count == $past(r_byte_count) + 11'd1, "byte count did not advance")

endmodule
`default_nettype wire
